### rtl/bfpa_pkg.sv
package bfpa_pkg;

  // Field widths
  localparam int OWNER_W = 8;
  localparam int SIZE_W  = 8;
  localparam int TOTAL_W = 10;
  localparam int PIDX_W  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // Running sums hold up to eight capacities plus one request without wrapping
  localparam int SUM_W = 12;

  localparam int NUM_SIZE_REGS = 6;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 10'd1023;
  localparam logic [TOTAL_W-1:0] TOTAL_CAP_RESET = 10'd100;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_PART0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_PART5  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_CAP   = 3'd6;

  // Opcodes
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef logic [NUM_SIZE_REGS-1:0][SIZE_W-1:0] size_arr_t;

  // Partition capacities after reset, partition five first
  localparam size_arr_t SIZE_RESET = {8'd2, 8'd8, 8'd10, 8'd15, 8'd25, 8'd40};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_FINISH
  } state_t;

  // One partition table entry
  typedef struct packed {
    logic              busy;
    logic [OWNER_W-1:0] owner;
    logic [SIZE_W-1:0]  req;
  } entry_t;

  // Table write port
  typedef struct packed {
    logic              en;
    logic [PIDX_W-1:0] idx;
    entry_t            data;
  } entry_wr_t;

  // Result of one item
  typedef struct packed {
    logic               success;
    logic [PIDX_W-1:0]  part_idx;
    logic [TOTAL_W-1:0] used;
    logic [TOTAL_W-1:0] free;
    logic [TOTAL_W-1:0] usable;
  } result_t;

  // Capacity of a partition; partitions past the size registers hold nothing
  function automatic logic [SIZE_W-1:0] cap_of(input size_arr_t sizes,
                                               input logic [PIDX_W-1:0] idx);
    logic [SIZE_W-1:0] c;
    c = '0;
    if (idx < PIDX_W'(NUM_SIZE_REGS)) begin
      c = sizes[idx];
    end
    return c;
  endfunction

endpackage

### rtl/bfpa_part_store.sv
module bfpa_part_store
  import bfpa_pkg::*;
#(
  parameter int NUM_PARTITIONS = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [PIDX_W-1:0] rd_idx,
  output entry_t            rd_entry,
  input  entry_wr_t         wr
);

  localparam int IW = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;

  logic               busy  [NUM_PARTITIONS];
  logic [OWNER_W-1:0] owner [NUM_PARTITIONS];
  logic [SIZE_W-1:0]  req   [NUM_PARTITIONS];

  logic [IW-1:0] ri;
  logic [IW-1:0] wi;

  assign ri = rd_idx[IW-1:0];
  assign wi = wr.idx[IW-1:0];

  // Busy bits clear on reset, owner and size only matter while busy
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PARTITIONS; i++) begin
        busy[i] <= 1'b0;
      end
    end else if (wr.en) begin
      busy[wi] <= wr.data.busy;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      owner[wi] <= wr.data.owner;
      req[wi]   <= wr.data.req;
    end
  end

  // Single read port at the scan position
  always_comb begin
    rd_entry.busy  = busy[ri];
    rd_entry.owner = owner[ri];
    rd_entry.req   = req[ri];
  end

endmodule

### rtl/bfpa_seq.sv
module bfpa_seq
  import bfpa_pkg::*;
#(
  parameter int NUM_PARTITIONS = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               op,
  input  logic [OWNER_W-1:0] owner,
  input  logic [SIZE_W-1:0]  req,
  input  size_arr_t          sizes,
  input  logic [TOTAL_W-1:0] total_cap,
  output logic               idle,
  input  logic               res_ready,
  output logic               res_valid,
  output result_t            res,
  output logic [PIDX_W-1:0]  rd_idx,
  input  entry_t             rd_entry,
  output entry_wr_t          wr
);

  localparam int CW = $clog2(NUM_PARTITIONS + 1);
  localparam logic [CW-1:0] LAST = CW'(NUM_PARTITIONS - 1);

  state_t state, state_next;

  logic [CW-1:0]      cnt;
  logic               op_code;
  logic [OWNER_W-1:0] op_owner;
  logic [SIZE_W-1:0]  op_req;
  logic               found;
  logic [PIDX_W-1:0]  best_idx;
  logic [SIZE_W-1:0]  best_left;
  logic [SIZE_W-1:0]  best_cap;
  logic [SIZE_W-1:0]  best_req;
  logic [SUM_W-1:0]   usum;
  logic [SUM_W-1:0]   osum;

  logic [PIDX_W-1:0]  scan_idx;
  logic [SIZE_W-1:0]  cap;
  logic [SIZE_W-1:0]  left;
  logic               take;
  logic [TOTAL_W-1:0] used_sat;
  logic [TOTAL_W-1:0] occ_sat;

  assign scan_idx = PIDX_W'(cnt);
  assign cap      = cap_of(sizes, scan_idx);
  assign left     = cap - op_req;

  // Shared compare unit: does the partition under the scan beat the best so far
  always_comb begin
    take = 1'b0;
    if (op_code == OP_ALLOC) begin
      take = !rd_entry.busy && (cap >= op_req) && (!found || (left < best_left));
    end else begin
      take = rd_entry.busy && (rd_entry.owner == op_owner) && !found;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = ST_SCAN;
      ST_SCAN:   if (cnt == LAST) state_next = ST_COMMIT;
      ST_COMMIT: state_next = ST_FINISH;
      ST_FINISH: if (res_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Outputs of the sequencer
  always_comb begin
    idle      = 1'b0;
    res_valid = 1'b0;
    wr        = '0;
    unique case (state)
      ST_IDLE:   idle = 1'b1;
      ST_SCAN:   ;
      ST_COMMIT: begin
        wr.en  = found;
        wr.idx = best_idx;
        if (op_code == OP_ALLOC) begin
          wr.data.busy  = 1'b1;
          wr.data.owner = op_owner;
          wr.data.req   = op_req;
        end
      end
      ST_FINISH: res_valid = 1'b1;
      default:   ;
    endcase
  end

  assign rd_idx = scan_idx;

  // Datapath: scan, then fold the table change into the sums
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          op_code  <= op;
          op_owner <= owner;
          op_req   <= req;
          cnt      <= '0;
          found    <= 1'b0;
          usum     <= '0;
          osum     <= '0;
        end
      end
      ST_SCAN: begin
        cnt <= cnt + 1'b1;
        if (take) begin
          found     <= 1'b1;
          best_idx  <= scan_idx;
          best_left <= left;
          best_cap  <= cap;
          best_req  <= rd_entry.req;
        end
        if (rd_entry.busy) begin
          usum <= usum + SUM_W'(rd_entry.req);
          osum <= osum + SUM_W'(cap);
        end
      end
      ST_COMMIT: begin
        if (found) begin
          if (op_code == OP_ALLOC) begin
            usum <= usum + SUM_W'(op_req);
            osum <= osum + SUM_W'(best_cap);
          end else begin
            usum <= usum - SUM_W'(best_req);
            osum <= osum - SUM_W'(best_cap);
          end
        end
      end
      ST_FINISH: ;
      default: ;
    endcase
  end

  // Totals saturate, free figures floor at zero
  assign used_sat = (usum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : usum[TOTAL_W-1:0];
  assign occ_sat  = (osum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : osum[TOTAL_W-1:0];

  always_comb begin
    res.success  = found;
    res.part_idx = found ? best_idx : '0;
    res.used     = used_sat;
    res.free     = (total_cap > used_sat) ? (total_cap - used_sat) : '0;
    res.usable   = (total_cap > occ_sat) ? (total_cap - occ_sat) : '0;
  end

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> cnt <= LAST)
    else $error("scan position past last partition");

  a_start_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && start) |=> (state == ST_SCAN && cnt == '0 && !found))
    else $error("item did not start a fresh scan");

  a_grant_fits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMMIT && found && op_code == OP_ALLOC) |-> best_cap >= op_req)
    else $error("granted partition smaller than request");

  a_no_change: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMMIT && !found) |=> (usum == $past(usum) && osum == $past(osum)))
    else $error("sums moved without a grant or release");

  a_fail_idx: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.success) |-> res.part_idx == '0)
    else $error("failed item reports a partition");

endmodule

### rtl/best_fit_partition_allocator_core.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_ready  opcode, owner_id, request_size
// out      output     out_valid/out_ready  success, partition_index, used_total,
//                                          free_total, usable_free
// cfg      input      cfg_we               cfg_index, cfg_data
//
// After acceptance an item is scanned one partition per cycle through the
// shared compare unit, a commit state then updates the table and the sums,
// and a finish state offers the result. The result sits in an output
// register, so a new item is taken while it waits. in_ready stays low from
// acceptance until the result has moved into the output register; while that
// register is still full the result is held back and in_ready stays low.
// Synchronous reset frees every partition and loads the default capacities.
module best_fit_partition_allocator_core
  import bfpa_pkg::*;
#(
  parameter int NUM_PARTITIONS = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  opcode,
  input  logic [OWNER_W-1:0]    owner_id,
  input  logic [SIZE_W-1:0]     request_size,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  success,
  output logic [PIDX_W-1:0]     partition_index,
  output logic [TOTAL_W-1:0]    used_total,
  output logic [TOTAL_W-1:0]    free_total,
  output logic [TOTAL_W-1:0]    usable_free,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  size_arr_t          sizes;
  logic [TOTAL_W-1:0] total_cap;

  logic        start;
  logic        idle;
  logic        res_ready;
  logic        res_valid;
  result_t     res;
  logic [PIDX_W-1:0] rd_idx;
  entry_t      rd_entry;
  entry_wr_t   wr;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sizes     <= SIZE_RESET;
      total_cap <= TOTAL_CAP_RESET;
    end else if (cfg_we) begin
      if (cfg_index <= REG_SIZE_PART5) begin
        sizes[cfg_index - REG_SIZE_PART0] <= cfg_data[SIZE_W-1:0];
      end else if (cfg_index == REG_TOTAL_CAP) begin
        total_cap <= cfg_data[TOTAL_W-1:0];
      end
    end
  end

  assign in_ready  = idle;
  assign start     = in_valid & idle;
  assign res_ready = !out_valid || out_ready;

  bfpa_part_store #(
    .NUM_PARTITIONS(NUM_PARTITIONS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_idx   (rd_idx),
    .rd_entry (rd_entry),
    .wr       (wr)
  );

  bfpa_seq #(
    .NUM_PARTITIONS(NUM_PARTITIONS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .op        (opcode),
    .owner     (owner_id),
    .req       (request_size),
    .sizes     (sizes),
    .total_cap (total_cap),
    .idle      (idle),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res),
    .rd_idx    (rd_idx),
    .rd_entry  (rd_entry),
    .wr        (wr)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      success         <= res.success;
      partition_index <= res.part_idx;
      used_total      <= res.used;
      free_total      <= res.free;
      usable_free     <= res.usable;
    end
  end

endmodule

### bench/best_fit_partition_allocator_core_tb.sv
`timescale 1ns / 100ps

module best_fit_partition_allocator_core_tb;
  import bfpa_pkg::*;

  localparam int NUM_PARTS = 6;
  localparam int ITEMS_PER_SETTING = 220;
  localparam int SETTLE_CYCLES = NUM_PARTS + 8;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = REG_TOTAL_CAP + 1'b1;

  // Capacity settings visited by the random part
  typedef enum int {
    CAP_DEFAULT,
    CAP_ALL_MAX,
    CAP_ALL_ZERO,
    CAP_RANDOM,
    CAP_TIED,
    CAP_MAX_NO_TOTAL,
    CAP_RANDOM_SMALL,
    CAP_DEFAULT_FULL,
    CAP_COUNT
  } cap_setting_t;

  // One row of the directed table: a register write or an item
  typedef struct {
    bit                    is_cfg;
    bit                    typed;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic                  op;
    logic [OWNER_W-1:0]    owner;
    logic [SIZE_W-1:0]     units;
    result_t               want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  opcode = OP_ALLOC;
  logic [OWNER_W-1:0]    owner_id = '0;
  logic [SIZE_W-1:0]     request_size = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  success;
  logic [PIDX_W-1:0]     partition_index;
  logic [TOTAL_W-1:0]    used_total;
  logic [TOTAL_W-1:0]    free_total;
  logic [TOTAL_W-1:0]    usable_free;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow of the allocator: capacities, total and the partition table
  logic [SIZE_W-1:0]  part_cap [NUM_PARTS];
  logic [TOTAL_W-1:0] total_cap;
  bit                 slot_busy [NUM_PARTS];
  logic [OWNER_W-1:0] slot_owner [NUM_PARTS];
  logic [SIZE_W-1:0]  slot_units [NUM_PARTS];

  result_t   pending_results [$];
  plan_row_t plan [$];

  int send_idle = 0;
  int recv_stall = 0;
  int mismatches = 0;
  int items_sent = 0;
  int results_checked = 0;
  int grants = 0;
  int releases = 0;
  int refusals = 0;
  int settings_run = 0;

  int idle_pct [4] = '{0, 45, 0, 29};
  int stall_pct [4] = '{0, 0, 45, 29};

  best_fit_partition_allocator_core #(
    .NUM_PARTITIONS(NUM_PARTS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .owner_id(owner_id),
    .request_size(request_size),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .success(success),
    .partition_index(partition_index),
    .used_total(used_total),
    .free_total(free_total),
    .usable_free(usable_free),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Best-fit grant or owner release, then totals rebuilt from the table
  function automatic result_t predict_item(input logic op, input logic [OWNER_W-1:0] who,
                                           input logic [SIZE_W-1:0] units);
    result_t r;
    int best;
    int best_left;
    int used_acc;
    int occ_acc;
    int p;
    r = '0;
    best = -1;
    best_left = 0;
    if (op == OP_ALLOC) begin
      for (p = 0; p < NUM_PARTS; p++) begin
        if (!slot_busy[p] && part_cap[p] >= units) begin
          if (best < 0 || int'(part_cap[p]) - int'(units) < best_left) begin
            best = p;
            best_left = int'(part_cap[p]) - int'(units);
          end
        end
      end
      if (best >= 0) begin
        slot_busy[best] = 1'b1;
        slot_owner[best] = who;
        slot_units[best] = units;
      end
    end else begin
      for (p = 0; p < NUM_PARTS; p++) begin
        if (best < 0 && slot_busy[p] && slot_owner[p] == who) begin
          best = p;
        end
      end
      if (best >= 0) begin
        slot_busy[best] = 1'b0;
        slot_owner[best] = '0;
        slot_units[best] = '0;
      end
    end
    if (best >= 0) begin
      r.success = 1'b1;
      r.part_idx = PIDX_W'(best);
      if (op == OP_ALLOC) grants++;
      else releases++;
    end else begin
      refusals++;
    end
    used_acc = 0;
    occ_acc = 0;
    for (p = 0; p < NUM_PARTS; p++) begin
      if (slot_busy[p]) begin
        used_acc += slot_units[p];
        occ_acc += part_cap[p];
      end
    end
    if (used_acc > TOTAL_MAX) used_acc = TOTAL_MAX;
    if (occ_acc > TOTAL_MAX) occ_acc = TOTAL_MAX;
    r.used = TOTAL_W'(used_acc);
    r.free = (total_cap > used_acc) ? TOTAL_W'(total_cap - used_acc) : '0;
    r.usable = (total_cap > occ_acc) ? TOTAL_W'(total_cap - occ_acc) : '0;
    return r;
  endfunction

  function automatic plan_row_t item_row(input logic op, input int who, input int units);
    plan_row_t row;
    row = '{default: '0};
    row.op = op;
    row.owner = OWNER_W'(who);
    row.units = SIZE_W'(units);
    return row;
  endfunction

  function automatic plan_row_t typed_row(input logic op, input int who, input int units,
                                          input int ok, input int idx, input int used,
                                          input int free, input int usable);
    plan_row_t row;
    row = item_row(op, who, units);
    row.typed = 1'b1;
    row.want = {1'(ok), PIDX_W'(idx), TOTAL_W'(used), TOTAL_W'(free), TOTAL_W'(usable)};
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input int val);
    plan_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = CFG_DATA_W'(val);
    return row;
  endfunction

  // Register write; the shadow copy follows the same decode
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx <= REG_SIZE_PART5) part_cap[idx - REG_SIZE_PART0] = val[SIZE_W-1:0];
    else if (idx == REG_TOTAL_CAP) total_cap = val;
    @(posedge clk);
  endtask

  // Sender holds off until every result is back and the core has gone quiet
  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offer one item, optionally after an idle gap; log its expected result on acceptance
  task automatic push_item(input logic op, input logic [OWNER_W-1:0] who,
                           input logic [SIZE_W-1:0] units, input bit typed,
                           input result_t typed_res);
    result_t res;
    if (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    opcode <= op;
    owner_id <= who;
    request_size <= units;
    do @(posedge clk); while (!in_ready);
    res = predict_item(op, who, units);
    pending_results.push_back(typed ? typed_res : res);
    items_sent++;
  endtask

  task automatic apply_setting(input cap_setting_t kind);
    logic [SIZE_W-1:0]  caps [NUM_PARTS];
    logic [TOTAL_W-1:0] total;
    int p;
    total = TOTAL_CAP_RESET;
    for (p = 0; p < NUM_PARTS; p++) begin
      case (kind)
        CAP_ALL_MAX, CAP_MAX_NO_TOTAL: caps[p] = '1;
        CAP_ALL_ZERO:                  caps[p] = '0;
        CAP_RANDOM:                    caps[p] = SIZE_W'($urandom);
        CAP_TIED:                      caps[p] = SIZE_W'(8 * $urandom_range(3, 1));
        CAP_RANDOM_SMALL:              caps[p] = SIZE_W'($urandom_range(60));
        default:                       caps[p] = SIZE_RESET[p];
      endcase
    end
    case (kind)
      CAP_ALL_MAX, CAP_DEFAULT_FULL:    total = TOTAL_MAX;
      CAP_ALL_ZERO, CAP_MAX_NO_TOTAL:   total = '0;
      CAP_RANDOM, CAP_RANDOM_SMALL:     total = TOTAL_W'($urandom);
      CAP_TIED:                         total = TOTAL_W'($urandom_range(140, 60));
      default:                          total = TOTAL_CAP_RESET;
    endcase
    // upper data bits are junk on the 8-bit registers
    for (p = 0; p < NUM_PARTS; p++) begin
      cfg_write(REG_SIZE_PART0 + CFG_IDX_W'(p), {2'($urandom), caps[p]});
    end
    cfg_write(REG_TOTAL_CAP, total);
    cfg_write(REG_UNUSED, CFG_DATA_W'($urandom));
  endtask

  // Mostly sensible traffic: fitting requests, releases of owners that hold something
  task automatic random_item();
    logic               op;
    logic [OWNER_W-1:0] who;
    logic [SIZE_W-1:0]  units;
    int held;
    int max_cap;
    int sel;
    int p;
    held = 0;
    max_cap = 0;
    for (p = 0; p < NUM_PARTS; p++) begin
      if (slot_busy[p]) held++;
      if (part_cap[p] > max_cap) max_cap = part_cap[p];
    end
    op = ($urandom_range(99) < ((held >= 4) ? 60 : 30)) ? OP_RELEASE : OP_ALLOC;
    units = SIZE_W'($urandom);
    who = ($urandom_range(99) < 70) ? OWNER_W'($urandom_range(6, 1)) : OWNER_W'($urandom);
    if (op == OP_RELEASE) begin
      if (held != 0 && $urandom_range(99) < 85) begin
        do p = $urandom_range(NUM_PARTS - 1); while (!slot_busy[p]);
        who = slot_owner[p];
      end
    end else begin
      sel = $urandom_range(9);
      if (sel >= 4) units = SIZE_W'($urandom_range(max_cap));
      else if (sel >= 2) units = part_cap[$urandom_range(NUM_PARTS - 1)];
    end
    push_item(op, who, units, 1'b0, '0);
  endtask

  // Receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  // Result checker
  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: success %0d partition_index %0d",
               success, partition_index);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("success", want.success, success);
        check_field("partition_index", want.part_idx, partition_index);
        check_field("used_total", want.used, used_total);
        check_field("free_total", want.free, free_total);
        check_field("usable_free", want.usable, usable_free);
        results_checked++;
      end
    end
  end

  // Stimulus
  initial begin
    int p;
    for (p = 0; p < NUM_PARTS; p++) begin
      part_cap[p] = SIZE_RESET[p];
      slot_busy[p] = 1'b0;
      slot_owner[p] = '0;
      slot_units[p] = '0;
    end
    total_cap = TOTAL_CAP_RESET;

    // reset state, no fit, exact fit, owner id extremes
    plan.push_back(typed_row(OP_RELEASE, 5, 0, 0, 0, 0, 100, 100));
    plan.push_back(typed_row(OP_ALLOC, 1, 255, 0, 0, 0, 100, 100));
    plan.push_back(typed_row(OP_ALLOC, 0, 0, 1, 5, 0, 100, 98));
    plan.push_back(typed_row(OP_ALLOC, 255, 40, 1, 0, 40, 60, 58));
    // best fit among several, duplicate owner, then a request nothing holds
    plan.push_back(item_row(OP_ALLOC, 7, 9));
    plan.push_back(item_row(OP_ALLOC, 7, 9));
    plan.push_back(item_row(OP_ALLOC, 8, 8));
    plan.push_back(item_row(OP_ALLOC, 9, 26));
    // duplicate owner frees lowest index first; size ignored on release
    plan.push_back(item_row(OP_RELEASE, 7, 255));
    plan.push_back(item_row(OP_RELEASE, 7, 0));
    plan.push_back(item_row(OP_RELEASE, 7, 0));
    plan.push_back(item_row(OP_RELEASE, 0, 0));
    plan.push_back(item_row(OP_RELEASE, 255, 0));
    plan.push_back(item_row(OP_RELEASE, 8, 0));
    // tie on leftover goes to the lower index
    plan.push_back(cfg_row(REG_SIZE_PART0 + 3'd1, 40));
    plan.push_back(item_row(OP_ALLOC, 3, 30));
    plan.push_back(item_row(OP_ALLOC, 4, 30));
    plan.push_back(item_row(OP_RELEASE, 3, 0));
    plan.push_back(item_row(OP_RELEASE, 4, 0));
    // totals floor at zero once capacity is below what is held
    plan.push_back(cfg_row(REG_TOTAL_CAP, 0));
    plan.push_back(typed_row(OP_ALLOC, 1, 2, 1, 5, 2, 0, 0));
    plan.push_back(typed_row(OP_RELEASE, 1, 0, 1, 5, 0, 0, 0));
    plan.push_back(cfg_row(REG_UNUSED, 1023));
    plan.push_back(item_row(OP_ALLOC, 2, 0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      if (plan[r].is_cfg) begin
        wait_all_results();
        cfg_write(plan[r].reg_idx, plan[r].reg_val);
      end else begin
        push_item(plan[r].op, plan[r].owner, plan[r].units, plan[r].typed, plan[r].want);
      end
    end

    // Random part, one capacity setting and one idling mix per phase
    for (int k = 0; k < int'(CAP_COUNT); k++) begin
      wait_all_results();
      apply_setting(cap_setting_t'(k));
      send_idle = idle_pct[k % 4];
      recv_stall = stall_pct[k % 4];
      settings_run++;
      for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
        random_item();
        if ($urandom_range(79) == 0) wait_all_results();
      end
    end

    in_valid <= 1'b0;
    recv_stall = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d items over %0d capacity settings, %0d results checked",
             items_sent, settings_run, results_checked);
    $display("Grants %0d, releases %0d, refused %0d, mismatches %0d",
             grants, releases, refusals, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("Timed out with %0d results outstanding", pending_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### files.f
rtl/bfpa_pkg.sv
rtl/bfpa_part_store.sv
rtl/bfpa_seq.sv
rtl/best_fit_partition_allocator_core.sv
bench/best_fit_partition_allocator_core_tb.sv
